[sv/uyvy_pkg.sv]
package uyvy_pkg;

    localparam int COEF_FRAC_BITS_DEF = 12;

    // widths of the fixed-point path
    localparam int PIX_W    = 8;
    localparam int DIFF_W   = 9;
    localparam int Y_W      = 10;
    localparam int SUM_W    = 11;
    localparam int SCL_W    = 19;
    localparam int PROD_EXT = 12;
    localparam int NUM_CH   = 6;

    localparam logic signed [Y_W-1:0]   Y_OFFSET     = 10'sd16;
    localparam logic signed [SCL_W-1:0] STUDIO_GAIN  = 19'sd220;
    localparam int                      STUDIO_SHIFT = 8;
    localparam logic signed [SCL_W-1:0] STUDIO_BIAS  = 19'sd255;
    localparam logic signed [SCL_W-1:0] PIX_MAX      = 19'sd255;

    // channel slots: first pixel then second pixel
    localparam int CH_R0 = 0;
    localparam int CH_G0 = 1;
    localparam int CH_B0 = 2;
    localparam int CH_R1 = 3;
    localparam int CH_G1 = 4;
    localparam int CH_B1 = 5;

    typedef enum logic {
        RANGE_FULL   = 1'b0,
        RANGE_STUDIO = 1'b1
    } t_range;

    typedef logic signed [Y_W-1:0]   t_luma;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [SCL_W-1:0] t_scl;
    typedef logic [PIX_W-1:0]        t_pix;

    typedef t_sum t_sum_arr [NUM_CH];
    typedef t_scl t_scl_arr [NUM_CH];
    typedef t_pix t_pix_arr [NUM_CH];

endpackage

[sv/uyvy_pair_to_rgb_converter.sv]
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_u_sample i_y_first i_v_sample i_y_second
// output    out        o_valid / i_stall      o_{red,green,blue}_{first,second}
// config    in         i_cfg_wr_en            i_cfg_wr_data (range mode)
//
// one uyvy word per cycle while i_stall does not hold the pipeline
// pipeline: products, channel sums, studio gain, shift and clamp
// reset clears the valid bits and sets full range
// a stall holds every stage that is full; empty stages still fill
module uyvy_pair_to_rgb_converter
    import uyvy_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_u_sample,
    input  logic [PIX_W-1:0] i_y_first,
    input  logic [PIX_W-1:0] i_v_sample,
    input  logic [PIX_W-1:0] i_y_second,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_red_first,
    output logic [PIX_W-1:0] o_green_first,
    output logic [PIX_W-1:0] o_blue_first,
    output logic [PIX_W-1:0] o_red_second,
    output logic [PIX_W-1:0] o_green_second,
    output logic [PIX_W-1:0] o_blue_second
);

    localparam int PROD_W = COEF_FRAC_BITS + PROD_EXT;

    t_range r_range_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_mode <= RANGE_FULL;
        end else if (i_cfg_wr_en) begin
            r_range_mode <= t_range'(i_cfg_wr_data);
        end
    end

    logic                     m_ready, m_valid;
    logic signed [PROD_W-1:0] p_rv, p_gv, p_gu, p_bu;
    t_luma                    m_y0, m_y1;
    t_range                   m_mode;
    logic                     s_ready, s_valid;
    t_sum_arr                 s_sum;
    t_range                   s_mode;
    logic                     c_ready;
    t_pix_arr                 pix;

    uyvy_mult #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (m_ready),
        .i_ready (s_ready),
        .o_valid (m_valid),
        .i_mode  (r_range_mode),
        .i_u     (i_u_sample),
        .i_v     (i_v_sample),
        .i_y0    (i_y_first),
        .i_y1    (i_y_second),
        .o_p_rv  (p_rv),
        .o_p_gv  (p_gv),
        .o_p_gu  (p_gu),
        .o_p_bu  (p_bu),
        .o_y0    (m_y0),
        .o_y1    (m_y1),
        .o_mode  (m_mode)
    );

    uyvy_sum #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_ready (s_ready),
        .i_ready (c_ready),
        .o_valid (s_valid),
        .i_p_rv  (p_rv),
        .i_p_gv  (p_gv),
        .i_p_gu  (p_gu),
        .i_p_bu  (p_bu),
        .i_y0    (m_y0),
        .i_y1    (m_y1),
        .i_mode  (m_mode),
        .o_sum   (s_sum),
        .o_mode  (s_mode)
    );

    uyvy_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_ready (c_ready),
        .i_ready (!i_stall),
        .o_valid (o_valid),
        .i_sum   (s_sum),
        .i_mode  (s_mode),
        .o_pix   (pix)
    );

    assign o_stall        = !m_ready;
    assign o_red_first    = pix[CH_R0];
    assign o_green_first  = pix[CH_G0];
    assign o_blue_first   = pix[CH_B0];
    assign o_red_second   = pix[CH_R1];
    assign o_green_second = pix[CH_G1];
    assign o_blue_second  = pix[CH_B1];

endmodule

[sv/uyvy_mult.sv]
module uyvy_mult
    import uyvy_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int PROD_W = COEF_FRAC_BITS + PROD_EXT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_ready,
    output logic                     o_valid,
    input  t_range                   i_mode,
    input  logic [PIX_W-1:0]         i_u,
    input  logic [PIX_W-1:0]         i_v,
    input  logic [PIX_W-1:0]         i_y0,
    input  logic [PIX_W-1:0]         i_y1,
    output logic signed [PROD_W-1:0] o_p_rv,
    output logic signed [PROD_W-1:0] o_p_gv,
    output logic signed [PROD_W-1:0] o_p_gu,
    output logic signed [PROD_W-1:0] o_p_bu,
    output t_luma                    o_y0,
    output t_luma                    o_y1,
    output t_range                   o_mode
);

    localparam int     COEF_W = COEF_FRAC_BITS + 3;
    localparam longint ONE    = longint'(1) << COEF_FRAC_BITS;

    localparam longint RV_F_L = (1370705 * ONE + 500000) / 1000000;
    localparam longint GV_F_L = (698001 * ONE + 500000) / 1000000;
    localparam longint GU_F_L = (337633 * ONE + 500000) / 1000000;
    localparam longint BU_F_L = (1732446 * ONE + 500000) / 1000000;
    localparam longint RV_S_L = (15958 * ONE + 5000) / 10000;
    localparam longint GV_S_L = (81290 * ONE + 50000) / 100000;
    localparam longint GU_S_L = (39173 * ONE + 50000) / 100000;
    localparam longint BU_S_L = (2017 * ONE + 500) / 1000;

    localparam logic signed [COEF_W-1:0] RV_F = COEF_W'(RV_F_L);
    localparam logic signed [COEF_W-1:0] GV_F = COEF_W'(GV_F_L);
    localparam logic signed [COEF_W-1:0] GU_F = COEF_W'(GU_F_L);
    localparam logic signed [COEF_W-1:0] BU_F = COEF_W'(BU_F_L);
    localparam logic signed [COEF_W-1:0] RV_S = COEF_W'(RV_S_L);
    localparam logic signed [COEF_W-1:0] GV_S = COEF_W'(GV_S_L);
    localparam logic signed [COEF_W-1:0] GU_S = COEF_W'(GU_S_L);
    localparam logic signed [COEF_W-1:0] BU_S = COEF_W'(BU_S_L);

    logic                      r_valid;
    logic signed [PROD_W-1:0]  r_p_rv, r_p_gv, r_p_gu, r_p_bu;
    t_luma                     r_y0, r_y1;
    t_range                    r_mode;

    logic signed [DIFF_W-1:0]  u_d, v_d;
    logic signed [COEF_W-1:0]  c_rv, c_gv, c_gu, c_bu;
    logic signed [PROD_W-1:0]  n_p_rv, n_p_gv, n_p_gu, n_p_bu;
    t_luma                     y0_ext, y1_ext, n_y0, n_y1;
    logic                      studio;

    // offset 128 removal is an msb flip
    assign u_d = signed'({{(DIFF_W-PIX_W+1){~i_u[PIX_W-1]}}, i_u[PIX_W-2:0]});
    assign v_d = signed'({{(DIFF_W-PIX_W+1){~i_v[PIX_W-1]}}, i_v[PIX_W-2:0]});

    assign studio = (i_mode == RANGE_STUDIO);
    assign c_rv   = studio ? RV_S : RV_F;
    assign c_gv   = studio ? GV_S : GV_F;
    assign c_gu   = studio ? GU_S : GU_F;
    assign c_bu   = studio ? BU_S : BU_F;

    assign n_p_rv = PROD_W'(c_rv) * PROD_W'(v_d);
    assign n_p_gv = PROD_W'(c_gv) * PROD_W'(v_d);
    assign n_p_gu = PROD_W'(c_gu) * PROD_W'(u_d);
    assign n_p_bu = PROD_W'(c_bu) * PROD_W'(u_d);

    assign y0_ext = signed'({{(Y_W-PIX_W){1'b0}}, i_y0});
    assign y1_ext = signed'({{(Y_W-PIX_W){1'b0}}, i_y1});
    assign n_y0   = studio ? y0_ext - Y_OFFSET : y0_ext;
    assign n_y1   = studio ? y1_ext - Y_OFFSET : y1_ext;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_p_rv <= n_p_rv;
            r_p_gv <= n_p_gv;
            r_p_gu <= n_p_gu;
            r_p_bu <= n_p_bu;
            r_y0   <= n_y0;
            r_y1   <= n_y1;
            r_mode <= i_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_p_rv  = r_p_rv;
    assign o_p_gv  = r_p_gv;
    assign o_p_gu  = r_p_gu;
    assign o_p_bu  = r_p_bu;
    assign o_y0    = r_y0;
    assign o_y1    = r_y1;
    assign o_mode  = r_mode;

endmodule

[sv/uyvy_sum.sv]
module uyvy_sum
    import uyvy_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int PROD_W = COEF_FRAC_BITS + PROD_EXT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_ready,
    output logic                     o_valid,
    input  logic signed [PROD_W-1:0] i_p_rv,
    input  logic signed [PROD_W-1:0] i_p_gv,
    input  logic signed [PROD_W-1:0] i_p_gu,
    input  logic signed [PROD_W-1:0] i_p_bu,
    input  t_luma                    i_y0,
    input  t_luma                    i_y1,
    input  t_range                   i_mode,
    output t_sum_arr                 o_sum,
    output t_range                   o_mode
);

    localparam logic signed [PROD_W-1:0] BIAS =
        PROD_W'((longint'(1) << COEF_FRAC_BITS) - 1);

    // divide by 2^frac, truncating toward zero
    function automatic t_sum trunc_div(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p + (p[PROD_W-1] ? BIAS : '0);
        return SUM_W'(q >>> COEF_FRAC_BITS);
    endfunction

    logic     r_valid;
    t_sum_arr r_sum;
    t_range   r_mode;

    t_sum_arr n_sum;
    t_sum     t_rv, t_gv, t_gu, t_bu, y0_s, y1_s;

    assign t_rv = trunc_div(i_p_rv);
    assign t_gv = trunc_div(i_p_gv);
    assign t_gu = trunc_div(i_p_gu);
    assign t_bu = trunc_div(i_p_bu);
    assign y0_s = SUM_W'(i_y0);
    assign y1_s = SUM_W'(i_y1);

    always_comb begin
        n_sum[CH_R0] = y0_s + t_rv;
        n_sum[CH_G0] = y0_s - t_gv - t_gu;
        n_sum[CH_B0] = y0_s + t_bu;
        n_sum[CH_R1] = y1_s + t_rv;
        n_sum[CH_G1] = y1_s - t_gv - t_gu;
        n_sum[CH_B1] = y1_s + t_bu;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum  <= n_sum;
            r_mode <= i_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_mode  = r_mode;

endmodule

[sv/uyvy_scale.sv]
module uyvy_scale
    import uyvy_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_ready,
    output logic     o_valid,
    input  t_sum_arr i_sum,
    input  t_range   i_mode,
    output t_pix_arr o_pix
);

    function automatic t_pix clamp8(input t_scl x);
        t_pix res;
        if (x[SCL_W-1]) begin
            res = '0;
        end else if (x > PIX_MAX) begin
            res = '1;
        end else begin
            res = x[PIX_W-1:0];
        end
        return res;
    endfunction

    logic     r_valid_a, r_valid_b;
    t_scl_arr r_scl;
    t_range   r_mode;
    t_pix_arr r_pix;

    t_scl_arr n_scl;
    t_pix_arr n_pix;
    t_scl     tmp [NUM_CH];
    logic     ready_a, ready_b;

    // stage a: studio gain of 220 in studio range; full range passes the sum through
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (i_mode == RANGE_STUDIO) begin
                n_scl[k] = SCL_W'(i_sum[k]) * STUDIO_GAIN;
            end else begin
                n_scl[k] = SCL_W'(i_sum[k]);
            end
        end
    end

    // stage b: in studio range shift by 8 toward zero; in both ranges clamp
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (r_mode == RANGE_STUDIO) begin
                tmp[k] = t_scl'(r_scl[k]
                                + (r_scl[k][SCL_W-1] ? STUDIO_BIAS : t_scl'(0)))
                         >>> STUDIO_SHIFT;
            end else begin
                tmp[k] = r_scl[k];
            end
            n_pix[k] = clamp8(tmp[k]);
        end
    end

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_scl  <= n_scl;
            r_mode <= i_mode;
        end
        if (ready_b && r_valid_a) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid_b;
    assign o_pix   = r_pix;

endmodule

[sv/uyvy_checker.sv]
module uyvy_checker
    import uyvy_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [PIX_W-1:0] o_red_first,
    input logic [PIX_W-1:0] o_green_first,
    input logic [PIX_W-1:0] o_blue_first,
    input logic [PIX_W-1:0] o_red_second,
    input logic [PIX_W-1:0] o_green_second,
    input logic [PIX_W-1:0] o_blue_second
);

    // a held output word keeps its valid and its pixels
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_first)
            && $stable(o_green_first) && $stable(o_blue_first)
            && $stable(o_red_second) && $stable(o_green_second)
            && $stable(o_blue_second))
        else $error("output word changed while stalled");

    // with the output left free, an accepted word shows up at the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted word did not reach the output");

    // input stalls only when the pipeline is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while pipeline had room");

endmodule

bind uyvy_pair_to_rgb_converter uyvy_checker u_uyvy_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import uyvy_pkg::*;

    typedef struct packed {
        t_pix u;
        t_pix y0;
        t_pix v;
        t_pix y1;
    } t_uyvy_word;

    typedef struct packed {
        t_pix r0;
        t_pix g0;
        t_pix b0;
        t_pix r1;
        t_pix g1;
        t_pix b1;
    } t_rgb_pair;

    localparam int WORDS_PER_SEGMENT = 68;
    localparam int HOLD_CYCLES       = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = RANGE_FULL;
    logic i_valid = 1'b0;
    logic o_stall;
    t_pix i_u_sample = '0;
    t_pix i_y_first = '0;
    t_pix i_v_sample = '0;
    t_pix i_y_second = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_pix o_red_first, o_green_first, o_blue_first;
    t_pix o_red_second, o_green_second, o_blue_second;

    t_uyvy_word pending_words[$];
    t_rgb_pair  rgb_expected[$];
    t_range     range_now = RANGE_FULL;
    bit         word_taken = 1'b0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_left = 0;
    int         results_seen = 0;
    int         errors = 0;

    uyvy_pair_to_rgb_converter u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_u_sample     (i_u_sample),
        .i_y_first      (i_y_first),
        .i_v_sample     (i_v_sample),
        .i_y_second     (i_y_second),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second)
    );

    always #2 clk = ~clk;

    // coefficient rounded to nearest at the block's fraction width
    function automatic int fx_coef(longint num, longint den);
        longint one;
        one = longint'(1) << COEF_FRAC_BITS_DEF;
        return int'((num * one + den / 2) / den);
    endfunction

    function automatic t_pix clamp_pix(int x);
        if (x < 0) begin
            return '0;
        end
        if (x > 255) begin
            return 8'd255;
        end
        return t_pix'(x);
    endfunction

    function automatic t_rgb_pair rgb_predict(t_uyvy_word w, t_range mode);
        int one, u, v, rv, gv, gu, bu, r_t, g_t, b_t;
        int luma[2];
        int r, g, b;
        t_pix chan[6];
        t_rgb_pair res;
        one = 1 << COEF_FRAC_BITS_DEF;
        u = int'(w.u) - 128;
        v = int'(w.v) - 128;
        luma[0] = int'(w.y0);
        luma[1] = int'(w.y1);
        if (mode == RANGE_STUDIO) begin
            rv = fx_coef(15958, 10000);
            gv = fx_coef(81290, 100000);
            gu = fx_coef(39173, 100000);
            bu = fx_coef(2017, 1000);
            luma[0] -= 16;
            luma[1] -= 16;
        end else begin
            rv = fx_coef(1370705, 1000000);
            gv = fx_coef(698001, 1000000);
            gu = fx_coef(337633, 1000000);
            bu = fx_coef(1732446, 1000000);
        end
        // each product truncated toward zero on its own
        r_t = (rv * v) / one;
        g_t = (gv * v) / one + (gu * u) / one;
        b_t = (bu * u) / one;
        for (int p = 0; p < 2; p++) begin
            r = luma[p] + r_t;
            g = luma[p] - g_t;
            b = luma[p] + b_t;
            if (mode == RANGE_STUDIO) begin
                r = (r * 220) / 256;
                g = (g * 220) / 256;
                b = (b * 220) / 256;
            end
            chan[3*p]     = clamp_pix(r);
            chan[3*p + 1] = clamp_pix(g);
            chan[3*p + 2] = clamp_pix(b);
        end
        res.r0 = chan[CH_R0];
        res.g0 = chan[CH_G0];
        res.b0 = chan[CH_B0];
        res.r1 = chan[CH_R1];
        res.g1 = chan[CH_G1];
        res.b1 = chan[CH_B1];
        return res;
    endfunction

    function automatic t_pix pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    task automatic mismatch_report(string what, int got, int want);
        $display("mismatch at word %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic push_word(int u, int y0, int v, int y1);
        t_uyvy_word w;
        w.u = t_pix'(u);
        w.y0 = t_pix'(y0);
        w.v = t_pix'(v);
        w.y1 = t_pix'(y1);
        pending_words.push_back(w);
    endtask

    task automatic push_directed();
        push_word(128, 0, 128, 255);
        push_word(0, 0, 0, 0);
        push_word(255, 255, 255, 255);
        push_word(255, 0, 255, 0);
        push_word(0, 255, 0, 255);
        push_word(255, 128, 0, 128);
        push_word(0, 128, 255, 128);
        push_word(128, 16, 128, 235);
        push_word(128, 15, 128, 0);
        push_word(170, 85, 85, 170);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge clk);
            #1;
        end while (pending_words.size() != 0 || i_valid || rgb_expected.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_range(t_range mode);
        @(negedge clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // sender
    always @(negedge clk) begin
        t_uyvy_word w;
        if (!rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                i_u_sample <= w.u;
                i_y_first  <= w.y0;
                i_v_sample <= w.v;
                i_y_second <= w.y1;
                i_valid    <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // accepted words and register writes
    always @(posedge clk) begin
        t_uyvy_word w;
        if (rst_n && i_valid && !o_stall) begin
            w.u = i_u_sample;
            w.y0 = i_y_first;
            w.v = i_v_sample;
            w.y1 = i_y_second;
            rgb_expected.push_back(rgb_predict(w, range_now));
            word_taken = 1'b1;
        end
        if (rst_n && i_cfg_wr_en) begin
            range_now <= t_range'(i_cfg_wr_data);
        end
    end

    // result checker
    always @(posedge clk) begin
        t_rgb_pair want;
        if (rst_n && o_valid && !i_stall) begin
            if (rgb_expected.size() == 0) begin
                mismatch_report("word with none expected", 0, 0);
            end else begin
                want = rgb_expected.pop_front();
                if (o_red_first !== want.r0)
                    mismatch_report("red_first", o_red_first, want.r0);
                if (o_green_first !== want.g0)
                    mismatch_report("green_first", o_green_first, want.g0);
                if (o_blue_first !== want.b0)
                    mismatch_report("blue_first", o_blue_first, want.b0);
                if (o_red_second !== want.r1)
                    mismatch_report("red_second", o_red_second, want.r1);
                if (o_green_second !== want.g1)
                    mismatch_report("green_second", o_green_second, want.g1);
                if (o_blue_second !== want.b1)
                    mismatch_report("blue_second", o_blue_second, want.b1);
            end
            results_seen++;
        end
    end

    initial begin
        #(2_000_000);
        $display("** uyvy_pair_to_rgb_converter: FAILED **");
        $finish;
    end

    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 84, 0, 36};
        stall_set = '{0, 0, 84, 36};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range first, then studio
        push_directed();
        wait_drained();
        write_range(RANGE_STUDIO);
        push_directed();
        wait_drained();

        for (int s = 0; s < 8; s++) begin
            write_range((s % 2) ? RANGE_STUDIO : RANGE_FULL);
            send_idle_pct = idle_set[s / 2];
            stall_pct     = stall_set[s / 2];
            for (int n = 0; n < WORDS_PER_SEGMENT; n++) begin
                push_word(pick_byte(), pick_byte(), pick_byte(), pick_byte());
            end
            // long hold-off while the sender keeps offering
            if (s < 2) begin
                @(posedge clk);
                hold_left = HOLD_CYCLES;
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("** uyvy_pair_to_rgb_converter: PASSED **");
        end else begin
            $display("** uyvy_pair_to_rgb_converter: FAILED **");
        end
        $finish;
    end

endmodule
